[rtl/pru_pkg.sv]
// Shared types and constants for the PNG row unfilter.
`timescale 1ns / 1ps

package pru_pkg;

    localparam int MAX_ROW_BYTES   = 8192;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int BPP_W  = $clog2(MAX_PIXEL_BYTES + 1);

    localparam int ROW_BYTES_W = 14;
    localparam int BPP_REG_W   = 4;
    localparam int HEIGHT_W    = 15;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_ROW_BYTES = 2'd0;
    localparam logic [1:0] REG_BPP       = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DATA  = 2'd1,
        OP_ERROR = 2'd2
    } op_kind_t;

    // Effective register values after clamping
    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [BPP_W-1:0]    bpp;
        logic [HEIGHT_W-1:0] height;
    } cfg_t;

    // One item handed from the front end to the reconstruction stage
    typedef struct packed {
        op_kind_t          kind;
        filt_t             filt;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              first_row;
        logic [7:0]        byte_in;
        logic              row_end;
        logic              image_end;
    } op_t;

endpackage

[rtl/png_row_unfilter.sv]
// Top level of the PNG row unfilter: register file, line buffer and pipeline.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  input     | in_valid / in_ready    | data_byte
//  output    | out_valid / out_ready  | pixel_byte, row_end, image_end, bad_filter
//  config    | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One byte per cycle while the output is not stalled; the byte and the line-buffer
// read at accept go into the stage register, then reconstruct into the output register.
// The line buffer is one RAM with one write and one read port; the byte above
// is read at accept and written back when the item leaves reconstruction.
// rst_n clears control state and pixel history; the line buffer is not cleared.
// A stalled output holds the reconstruction stage and with it in_ready.
`timescale 1ns / 1ps

module png_row_unfilter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pru_pkg::ADDR_W-1:0]  paddr,
    input  logic [pru_pkg::DATA_W-1:0]  pwdata,
    output logic [pru_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  data_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  pixel_byte,
    output logic                        row_end,
    output logic                        image_end,
    output logic                        bad_filter
);

    logic [pru_pkg::ROW_BYTES_W-1:0] row_bytes_reg;
    logic [pru_pkg::BPP_REG_W-1:0]   bpp_reg;
    logic [pru_pkg::HEIGHT_W-1:0]    height_reg;
    logic                            cfg_wr;
    logic [1:0]                      reg_idx;
    pru_pkg::cfg_t                   cfg;

    logic                            can_take;
    logic                            op_valid;
    pru_pkg::op_t                    op;
    logic                            rd_en, wr_en;
    logic [pru_pkg::COL_W-1:0]       rd_addr, wr_addr;
    logic [7:0]                      wr_data, above_byte;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= pru_pkg::ROW_BYTES_W'(1);
            bpp_reg       <= pru_pkg::BPP_REG_W'(1);
            height_reg    <= pru_pkg::HEIGHT_W'(1);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                pru_pkg::REG_ROW_BYTES: row_bytes_reg <= pwdata[pru_pkg::ROW_BYTES_W-1:0];
                pru_pkg::REG_BPP:       bpp_reg       <= pwdata[pru_pkg::BPP_REG_W-1:0];
                pru_pkg::REG_HEIGHT:    height_reg    <= pwdata[pru_pkg::HEIGHT_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pru_pkg::REG_ROW_BYTES: prdata = pru_pkg::DATA_W'(row_bytes_reg);
            pru_pkg::REG_BPP:       prdata = pru_pkg::DATA_W'(bpp_reg);
            pru_pkg::REG_HEIGHT:    prdata = pru_pkg::DATA_W'(height_reg);
            default:                prdata = '0;
        endcase
    end

    // Clamp registers to their working range
    always_comb
    begin
        if (row_bytes_reg == '0)
        begin
            cfg.len = pru_pkg::LEN_W'(1);
        end
        else if (32'(row_bytes_reg) > 32'(pru_pkg::MAX_ROW_BYTES))
        begin
            cfg.len = pru_pkg::LEN_W'(pru_pkg::MAX_ROW_BYTES);
        end
        else
        begin
            cfg.len = pru_pkg::LEN_W'(row_bytes_reg);
        end

        if (bpp_reg == '0)
        begin
            cfg.bpp = pru_pkg::BPP_W'(1);
        end
        else if (32'(bpp_reg) > 32'(pru_pkg::MAX_PIXEL_BYTES))
        begin
            cfg.bpp = pru_pkg::BPP_W'(pru_pkg::MAX_PIXEL_BYTES);
        end
        else
        begin
            cfg.bpp = pru_pkg::BPP_W'(bpp_reg);
        end

        cfg.height = (height_reg == '0) ? pru_pkg::HEIGHT_W'(1) : height_reg;
    end

    pru_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .data_byte (data_byte),
        .can_take  (can_take),
        .in_ready  (in_ready),
        .op_valid  (op_valid),
        .op        (op),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    pru_ram #(
        .WIDTH (8),
        .DEPTH (pru_pkg::MAX_ROW_BYTES)
    ) u_line_buf (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (above_byte)
    );

    pru_recon u_recon (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op         (op),
        .above_byte (above_byte),
        .can_take   (can_take),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_byte (pixel_byte),
        .row_end    (row_end),
        .image_end  (image_end),
        .bad_filter (bad_filter)
    );

endmodule

[rtl/pru_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps

module pru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/pru_front.sv]
// Row and column tracking, filter-type decode and line-buffer read issue.
`timescale 1ns / 1ps

module pru_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pru_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    input  logic [7:0]                data_byte,
    input  logic                      can_take,
    output logic                      in_ready,
    output logic                      op_valid,
    output pru_pkg::op_t              op,
    output logic                      rd_en,
    output logic [pru_pkg::COL_W-1:0] rd_addr
);

    logic                                awaiting_reg, awaiting_next;
    logic                                halted_reg, halted_next;
    logic [pru_pkg::HEIGHT_W-1:0]        row_count_reg, row_count_next;
    logic [pru_pkg::COL_W-1:0]           col_reg, col_next;
    // slot_reg[k-1] holds the column modulo k, so a new pixel size applies at once
    logic [pru_pkg::SLOT_W-1:0]          slot_reg [pru_pkg::MAX_PIXEL_BYTES];
    logic [pru_pkg::SLOT_W-1:0]          slot_next [pru_pkg::MAX_PIXEL_BYTES];
    pru_pkg::filt_t                      filt_reg, filt_next;

    logic                                accept;
    logic                                active;
    logic                                at_end;
    logic [pru_pkg::HEIGHT_W-1:0]        row_inc;
    logic [pru_pkg::SLOT_W-1:0]          slot_sel;

    assign in_ready = can_take;
    assign accept   = in_valid && can_take;
    assign active   = !halted_reg && (row_count_reg < cfg.height);
    assign at_end   = (pru_pkg::LEN_W'(col_reg) + pru_pkg::LEN_W'(1)) >= cfg.len;
    assign row_inc  = row_count_reg + pru_pkg::HEIGHT_W'(1);
    assign slot_sel = pru_pkg::SLOT_W'(cfg.bpp - pru_pkg::BPP_W'(1));

    assign rd_addr = col_reg;

    always_comb
    begin
        awaiting_next  = awaiting_reg;
        halted_next    = halted_reg;
        row_count_next = row_count_reg;
        col_next       = col_reg;
        for (int i = 0; i < pru_pkg::MAX_PIXEL_BYTES; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        filt_next      = filt_reg;
        op_valid       = 1'b0;
        rd_en          = 1'b0;

        op.kind      = pru_pkg::OP_DATA;
        op.filt      = filt_reg;
        op.col       = col_reg;
        op.slot      = slot_reg[slot_sel];
        op.first_row = (row_count_reg == '0);
        op.byte_in   = data_byte;
        op.row_end   = at_end;
        op.image_end = at_end && (row_inc >= cfg.height);

        if (accept && active)
        begin
            op_valid = 1'b1;
            if (awaiting_reg)
            begin
                if (data_byte > 8'(pru_pkg::FILT_PAETH))
                begin
                    // unknown type: report once and stop
                    op.kind     = pru_pkg::OP_ERROR;
                    halted_next = 1'b1;
                end
                else
                begin
                    op.kind       = pru_pkg::OP_CLEAR;
                    filt_next     = pru_pkg::filt_t'(data_byte[2:0]);
                    awaiting_next = 1'b0;
                    col_next      = '0;
                    for (int i = 0; i < pru_pkg::MAX_PIXEL_BYTES; i++)
                    begin
                        slot_next[i] = '0;
                    end
                end
            end
            else
            begin
                rd_en = 1'b1;
                if (at_end)
                begin
                    row_count_next = row_inc;
                    awaiting_next  = 1'b1;
                    col_next       = '0;
                    for (int i = 0; i < pru_pkg::MAX_PIXEL_BYTES; i++)
                    begin
                        slot_next[i] = '0;
                    end
                end
                else
                begin
                    col_next = col_reg + pru_pkg::COL_W'(1);
                    for (int i = 0; i < pru_pkg::MAX_PIXEL_BYTES; i++)
                    begin
                        slot_next[i] = (slot_reg[i] == pru_pkg::SLOT_W'(i)) ?
                                       '0 : slot_reg[i] + pru_pkg::SLOT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b1;
            halted_reg    <= 1'b0;
            row_count_reg <= '0;
            col_reg       <= '0;
            for (int i = 0; i < pru_pkg::MAX_PIXEL_BYTES; i++)
            begin
                slot_reg[i] <= '0;
            end
            filt_reg      <= pru_pkg::FILT_NONE;
        end
        else
        begin
            awaiting_reg  <= awaiting_next;
            halted_reg    <= halted_next;
            row_count_reg <= row_count_next;
            col_reg       <= col_next;
            for (int i = 0; i < pru_pkg::MAX_PIXEL_BYTES; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
            filt_reg      <= filt_next;
        end
    end

endmodule

[rtl/pru_recon.sv]
// Prediction, byte reconstruction, pixel history and the output register.
`timescale 1ns / 1ps

module pru_recon (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      op_valid,
    input  pru_pkg::op_t              op,
    input  logic [7:0]                above_byte,
    output logic                      can_take,
    output logic                      wr_en,
    output logic [pru_pkg::COL_W-1:0] wr_addr,
    output logic [7:0]                wr_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                pixel_byte,
    output logic                      row_end,
    output logic                      image_end,
    output logic                      bad_filter
);

    logic                 s1_valid_reg, s1_valid_next;
    pru_pkg::op_t         s1_op_reg;
    logic [7:0]           left_reg [pru_pkg::MAX_PIXEL_BYTES];
    logic [7:0]           upleft_reg [pru_pkg::MAX_PIXEL_BYTES];
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           pixel_reg;
    logic                 row_end_reg, image_end_reg, bad_filter_reg;

    logic                 s1_emits, s1_adv;
    logic [7:0]           a, b, c, pred, val;
    logic [8:0]           sum_ab;
    logic [9:0]           p_a, p_b, p_c;
    logic [9:0]           dist_a, dist_b, dist_c;

    assign s1_emits = (s1_op_reg.kind != pru_pkg::OP_CLEAR);
    assign s1_adv   = s1_valid_reg && (!s1_emits || !out_valid_reg || out_ready);
    assign can_take = !s1_valid_reg || s1_adv;

    assign a = left_reg[s1_op_reg.slot];
    assign c = upleft_reg[s1_op_reg.slot];
    assign b = s1_op_reg.first_row ? 8'd0 : above_byte;

    // Paeth distances: |b-c|, |a-c|, |a+b-2c|
    assign sum_ab = {1'b0, a} + {1'b0, b};
    assign p_a    = {2'b00, b} - {2'b00, c};
    assign p_b    = {2'b00, a} - {2'b00, c};
    assign p_c    = {1'b0, sum_ab} - {1'b0, c, 1'b0};
    assign dist_a = p_a[9] ? -p_a : p_a;
    assign dist_b = p_b[9] ? -p_b : p_b;
    assign dist_c = p_c[9] ? -p_c : p_c;

    always_comb
    begin
        case (s1_op_reg.filt)
            pru_pkg::FILT_SUB:   pred = a;
            pru_pkg::FILT_UP:    pred = b;
            pru_pkg::FILT_AVG:   pred = sum_ab[8:1];
            pru_pkg::FILT_PAETH:
            begin
                if (dist_a <= dist_b && dist_a <= dist_c)
                begin
                    pred = a;
                end
                else if (dist_b <= dist_c)
                begin
                    pred = b;
                end
                else
                begin
                    pred = c;
                end
            end
            default:             pred = 8'd0;
        endcase
    end

    assign val = s1_op_reg.byte_in + pred;

    assign wr_en   = s1_adv && (s1_op_reg.kind == pru_pkg::OP_DATA);
    assign wr_addr = s1_op_reg.col;
    assign wr_data = val;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (can_take)
        begin
            s1_valid_next = op_valid;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_emits)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && op_valid)
        begin
            s1_op_reg <= op;
        end
        if (s1_adv && s1_emits)
        begin
            pixel_reg      <= (s1_op_reg.kind == pru_pkg::OP_DATA) ? val : 8'd0;
            row_end_reg    <= (s1_op_reg.kind == pru_pkg::OP_DATA) && s1_op_reg.row_end;
            image_end_reg  <= (s1_op_reg.kind == pru_pkg::OP_DATA) && s1_op_reg.image_end;
            bad_filter_reg <= (s1_op_reg.kind == pru_pkg::OP_ERROR);
        end
    end

    // Pixel history: cleared at each row start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pru_pkg::MAX_PIXEL_BYTES; i++)
            begin
                left_reg[i]   <= 8'd0;
                upleft_reg[i] <= 8'd0;
            end
        end
        else if (s1_adv)
        begin
            if (s1_op_reg.kind == pru_pkg::OP_CLEAR)
            begin
                for (int i = 0; i < pru_pkg::MAX_PIXEL_BYTES; i++)
                begin
                    left_reg[i]   <= 8'd0;
                    upleft_reg[i] <= 8'd0;
                end
            end
            else if (s1_op_reg.kind == pru_pkg::OP_DATA)
            begin
                left_reg[s1_op_reg.slot]   <= val;
                upleft_reg[s1_op_reg.slot] <= b;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_reg;
    assign row_end    = row_end_reg;
    assign image_end  = image_end_reg;
    assign bad_filter = bad_filter_reg;

endmodule

[test/pixel_checker.sv]
// Checker for the PNG row unfilter: watches all ports, predicts every pixel and compares.
`timescale 1ns / 1ps

module pixel_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pru_pkg::ADDR_W-1:0]  paddr,
    input  logic [pru_pkg::DATA_W-1:0]  pwdata,
    input  logic [pru_pkg::DATA_W-1:0]  prdata,
    input  logic                        pready,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [7:0]                  pixel_byte,
    input  logic                        row_end,
    input  logic                        image_end,
    input  logic                        bad_filter,
    output int                          fail_count,
    output int                          pending
);

    import pru_pkg::*;

    typedef struct packed {
        logic [7:0] pix;
        logic       rend;
        logic       iend;
        logic       bad;
    } pixel_result_t;

    pixel_result_t pending_pixels[$];

    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [BPP_REG_W-1:0]   bpp_reg;
    logic [HEIGHT_W-1:0]    height_reg;

    logic [7:0]  line_mem [0:MAX_ROW_BYTES-1];
    logic [7:0]  left_px [0:MAX_PIXEL_BYTES-1];
    logic [7:0]  upleft_px [0:MAX_PIXEL_BYTES-1];
    logic [12:0] col_cnt;
    logic [14:0] row_cnt;
    filt_t       kind;
    logic        awaiting;
    logic        halted;

    pixel_result_t      got_pixel;
    logic [DATA_W-1:0]  readback_want;
    logic               readback_known;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int p, pa, pb, pc;
        p  = int'(a) + int'(b) - int'(c);
        pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
        pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
        pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    task automatic clear_history();
        for (int i = 0; i < MAX_PIXEL_BYTES; i++)
        begin
            left_px[i]   = 8'h00;
            upleft_px[i] = 8'h00;
        end
    endtask

    // Reconstruct one accepted byte and queue the pixel it produces, if any.
    task automatic unfilter_byte(input logic [7:0] b);
        int                len, bpp, hgt;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        a, up, c, pred, val;
        logic              at_end;
        pixel_result_t     r;
        len = (row_bytes_reg == 0) ? 1 :
              (int'(row_bytes_reg) > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(row_bytes_reg);
        bpp = (bpp_reg == 0) ? 1 :
              (int'(bpp_reg) > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : int'(bpp_reg);
        hgt = (height_reg == 0) ? 1 : int'(height_reg);
        if (halted || int'(row_cnt) >= hgt)
            return;
        if (awaiting)
        begin
            if (b > 8'(FILT_PAETH))
            begin
                halted = 1'b1;
                r.pix  = 8'h00;
                r.rend = 1'b0;
                r.iend = 1'b0;
                r.bad  = 1'b1;
                pending_pixels.push_back(r);
                return;
            end
            kind     = filt_t'(b[2:0]);
            awaiting = 1'b0;
            col_cnt  = '0;
            clear_history();
            return;
        end
        slot = SLOT_W'(int'(col_cnt) % bpp);
        a    = left_px[slot];
        c    = upleft_px[slot];
        up   = (row_cnt == 0) ? 8'h00 : line_mem[col_cnt];
        case (kind)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = up;
            FILT_AVG:   pred = 8'((9'(a) + 9'(up)) >> 1);
            FILT_PAETH: pred = paeth_pick(a, up, c);
            default:    pred = 8'h00;
        endcase
        val = b + pred;
        upleft_px[slot]   = up;
        left_px[slot]     = val;
        line_mem[col_cnt] = val;
        at_end = (int'(col_cnt) + 1 >= len);
        r.pix  = val;
        r.rend = at_end;
        r.iend = 1'b0;
        r.bad  = 1'b0;
        if (at_end)
        begin
            row_cnt  = row_cnt + 1'b1;
            awaiting = 1'b1;
            col_cnt  = '0;
            r.iend   = (int'(row_cnt) >= hgt);
        end
        else
        begin
            col_cnt = col_cnt + 1'b1;
        end
        pending_pixels.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg = ROW_BYTES_W'(1);
            bpp_reg       = BPP_REG_W'(1);
            height_reg    = HEIGHT_W'(1);
            col_cnt       = '0;
            row_cnt       = '0;
            kind          = FILT_NONE;
            awaiting      = 1'b1;
            halted        = 1'b0;
            fail_count    = 0;
            clear_history();
            pending_pixels.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                readback_known = 1'b1;
                case (paddr[3:2])
                    REG_ROW_BYTES: readback_want = DATA_W'(row_bytes_reg);
                    REG_BPP:       readback_want = DATA_W'(bpp_reg);
                    REG_HEIGHT:    readback_want = DATA_W'(height_reg);
                    default:       readback_known = 1'b0;
                endcase
                if (pwrite)
                begin
                    case (paddr[3:2])
                        REG_ROW_BYTES: row_bytes_reg = pwdata[ROW_BYTES_W-1:0];
                        REG_BPP:       bpp_reg       = pwdata[BPP_REG_W-1:0];
                        REG_HEIGHT:    height_reg    = pwdata[HEIGHT_W-1:0];
                        default:       ;
                    endcase
                end
                else if (readback_known && prdata !== readback_want)
                begin
                    $display("%0t: register read at %0d, expected %0d, actual %0d",
                             $time, paddr, readback_want, prdata);
                    fail_count++;
                end
            end
            if (in_valid && in_ready)
                unfilter_byte(data_byte);
            if (out_valid && out_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual pixel %0d",
                             $time, pixel_byte);
                    fail_count++;
                end
                else
                begin
                    got_pixel = pending_pixels.pop_front();
                    check_field("pixel_byte", int'(got_pixel.pix), int'(pixel_byte));
                    check_field("row_end", int'(got_pixel.rend), int'(row_end));
                    check_field("image_end", int'(got_pixel.iend), int'(image_end));
                    check_field("bad_filter", int'(got_pixel.bad), int'(bad_filter));
                end
            end
            pending <= pending_pixels.size();
        end
    end

endmodule

[test/testbench.sv]
// Top of the PNG row unfilter test: clock, reset, register setup, byte stream and verdict.
`timescale 1ns / 1ps

module testbench;

    import pru_pkg::*;

    localparam int         CYCLE_LIMIT    = 600000;
    localparam int         RANDOM_ITEMS   = 330;
    localparam int         WIDE_ROW       = 160;
    localparam int         FULL_HEIGHT    = 32767;
    localparam logic [7:0] FIRST_BAD_TYPE = 8'd5;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [7:0]        data_byte = 8'h00;
    logic              out_valid;
    logic              out_ready = 1'b1;
    logic [7:0]        pixel_byte;
    logic              row_end;
    logic              image_end;
    logic              bad_filter;
    int                fail_count;
    int                pending;

    int cycles      = 0;
    int rows_done   = 0;
    int data_sent   = 0;
    int sink_wait   = 0;
    bit src_rush    = 1'b0;
    bit sink_rush   = 1'b0;

    png_row_unfilter DUT (.*);

    pixel_checker CHK (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Output side: after each item hold ready low for a random count of cycles.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            sink_wait = sink_rush ? 0 : $urandom_range(0, 3);
            if (sink_wait != 0)
                out_ready <= 1'b0;
        end
        else if (!out_ready)
        begin
            if (sink_wait <= 1)
                out_ready <= 1'b1;
            else
                sink_wait = sink_wait - 1;
        end
    end

    function automatic int row_len(input int v);
        if (v == 0)
            return 1;
        if (v > MAX_ROW_BYTES)
            return MAX_ROW_BYTES;
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_rush ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every pixel is out and the pipeline has emptied.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // read back the same register
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_row(input filt_t kind, input int len, input bit edgy);
        logic [7:0] v;
        send_byte(8'(kind));
        for (int i = 0; i < len; i++)
        begin
            if (edgy)
            begin
                case ($urandom_range(0, 4))
                    0:       v = 8'h00;
                    1:       v = 8'hFF;
                    2:       v = 8'h80;
                    3:       v = 8'h7F;
                    default: v = 8'($urandom_range(0, 255));
                endcase
            end
            else
            begin
                v = 8'($urandom_range(0, 255));
            end
            send_byte(v);
        end
        rows_done = rows_done + 1;
        data_sent = data_sent + len + 1;
    endtask

    task automatic send_noise(input int count);
        repeat (count) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int len_sel, len_val, nrows;
        bit cut;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // First row is as wide as any later row; the row above is zero here.
        set_reg(REG_ROW_BYTES, WIDE_ROW);
        set_reg(REG_BPP, 32'd9);
        set_reg(REG_HEIGHT, FULL_HEIGHT);
        send_row(FILT_PAETH, WIDE_ROW, 1'b0);

        settle();
        set_reg(REG_ROW_BYTES, 32'd4);
        set_reg(REG_BPP, 32'd1);
        send_row(FILT_NONE, 4, 1'b1);
        send_row(FILT_SUB, 4, 1'b1);
        send_row(FILT_UP, 4, 1'b1);
        settle();
        set_reg(REG_BPP, 32'd2);
        send_row(FILT_AVG, 4, 1'b1);
        send_row(FILT_PAETH, 4, 1'b1);

        // Zero row length and pixel size act as one.
        settle();
        set_reg(REG_ROW_BYTES, 32'd0);
        set_reg(REG_BPP, 32'd0);
        send_row(FILT_AVG, 1, 1'b1);

        // Shrink the row length partway through a row: the next byte ends it.
        settle();
        set_reg(REG_ROW_BYTES, 32'd8);
        set_reg(REG_BPP, 32'd3);
        send_byte(8'(FILT_PAETH));
        send_noise(5);
        settle();
        set_reg(REG_ROW_BYTES, 32'd3);
        send_noise(1);
        rows_done = rows_done + 1;

        // Last row of the image, then bytes that must be ignored.
        settle();
        set_reg(REG_ROW_BYTES, 32'd6);
        set_reg(REG_HEIGHT, rows_done + 1);
        send_row(FILT_SUB, 6, 1'b1);
        send_noise(3);
        settle();
        set_reg(REG_HEIGHT, 32'd0);
        send_noise(2);

        data_sent = 0;
        while (data_sent < RANDOM_ITEMS)
        begin
            settle();
            len_sel = $urandom_range(0, 9);
            if (len_sel == 0)
                len_val = 0;
            else if (len_sel <= 7)
                len_val = $urandom_range(1, 16);
            else if (len_sel == 8)
                len_val = $urandom_range(17, 64);
            else
                len_val = $urandom_range(65, WIDE_ROW);
            nrows     = $urandom_range(1, 3);
            cut       = ($urandom_range(0, 7) == 0);
            src_rush  = ($urandom_range(0, 3) == 0);
            sink_rush = ($urandom_range(0, 3) == 0);
            set_reg(REG_ROW_BYTES, len_val);
            set_reg(REG_BPP, $urandom_range(0, 15));
            set_reg(REG_HEIGHT, cut ? rows_done + nrows : FULL_HEIGHT);
            repeat (nrows) send_row(filt_t'($urandom_range(0, 4)), row_len(len_val), 1'b0);
            if (cut)
                send_noise($urandom_range(1, 4));
        end
        src_rush  = 1'b0;
        sink_rush = 1'b0;

        // Widest row against a full row above.
        settle();
        set_reg(REG_ROW_BYTES, WIDE_ROW);
        set_reg(REG_BPP, MAX_PIXEL_BYTES);
        set_reg(REG_HEIGHT, FULL_HEIGHT);
        send_row(filt_t'($urandom_range(1, 4)), WIDE_ROW, 1'b0);

        // Unknown filter type halts the block for good.
        send_byte(8'($urandom_range(FIRST_BAD_TYPE, 255)));
        send_noise(3);
        settle();
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
